@@ hw/rtl/bdq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and codes for the bounded deque: beat structs, mode and
// status codes, and the command that drives the row of storage cells.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int ENT_W = 5;

	localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [2:0] MODE_PUSH_BACK = 3'd1;
	localparam logic [2:0] MODE_POP_FRONT = 3'd2;
	localparam logic [2:0] MODE_POP_BACK = 3'd3;
	localparam logic [2:0] MODE_DUMP = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [2:0] mode;
		logic signed [DATA_W-1:0] value;
	} req_beat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic [1:0] status;
		logic [ENT_W-1:0] entries;
		logic last;
	} rsp_beat_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic [CNT_W-1:0] count;
		logic signed [DATA_W-1:0] value;
	} cell_cmd_t;

endpackage
`default_nettype wire

@@ hw/rtl/bdq_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_cell
// One storage cell of the deque row. Holds one entry and takes its next
// value from itself, a neighbor, the front cell or the pushed value.
// ----------------------------------------------------------------------------
module bdq_cell
	import bdq_pkg::*;
(
	input  wire logic clk,
	input  wire cell_cmd_t cmd,
	input  wire logic [IDX_W-1:0] idx,
	input  wire logic signed [DATA_W-1:0] left_d,
	input  wire logic signed [DATA_W-1:0] right_d,
	input  wire logic signed [DATA_W-1:0] head_d,
	output logic signed [DATA_W-1:0] q,
	output logic signed [DATA_W-1:0] back_d
);

	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] data_d;
	logic [CNT_W-1:0] pos;
	logic [CNT_W-1:0] pos_n;
	logic at_tail;
	logic at_back;
	logic before_back;

	assign pos = CNT_W'(idx);
	assign pos_n = pos + CNT_W'(1);
	assign at_tail = (pos == cmd.count);
	assign at_back = (pos_n == cmd.count);
	assign before_back = (pos_n < cmd.count);

	always_comb begin
		data_d = data_q;
		unique case (cmd.op)
			OP_HOLD: data_d = data_q;
			OP_PUSH_FRONT: data_d = (pos == '0) ? cmd.value : left_d;
			OP_PUSH_BACK: data_d = at_tail ? cmd.value : data_q;
			OP_POP_FRONT: data_d = right_d;
			OP_ROTATE: begin
				if (at_back)
					data_d = head_d;
				else if (before_back)
					data_d = right_d;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign q = data_q;
	assign back_d = at_back ? data_q : '0;

endmodule
`default_nettype wire

@@ hw/rtl/bdq_chain.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_chain
// Row of storage cells, front entry in cell zero. Shifts either way,
// rotates the held span for a dump, and reads out the back entry.
// ----------------------------------------------------------------------------
module bdq_chain
	import bdq_pkg::*;
(
	input  wire logic clk,
	input  wire cell_cmd_t cmd,
	output logic signed [DATA_W-1:0] head,
	output logic signed [DATA_W-1:0] back
);

	logic signed [DATA_W-1:0] cell_q [DEPTH];
	logic signed [DATA_W-1:0] cell_back [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		bdq_cell u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.idx     (IDX_W'(i)),
			.left_d  (cell_q[(i + DEPTH - 1) % DEPTH]),
			.right_d (cell_q[(i + 1) % DEPTH]),
			.head_d  (cell_q[0]),
			.q       (cell_q[i]),
			.back_d  (cell_back[i])
		);
	end

	always_comb begin
		back = '0;
		for (int i = 0; i < DEPTH; i++)
			back = back | cell_back[i];
	end

	assign head = cell_q[0];

endmodule
`default_nettype wire

@@ hw/rtl/bounded_deque_top.sv @@
// Push and pop: one beat out, registered in the cycle after the request beat.
// Push and pop requests are taken one per cycle while the response side flows.
// Dump: count beats (one EMPTY beat if empty), one per cycle while the response side flows,
// the first registered after dump_q is set; requests stall until the final dump beat is registered.
// Reset clears the entry count and control; cell contents are undefined until pushed.
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_deque_top
// Bounded double-ended queue of signed 32-bit values on a row of cells,
// with push/pop at both ends and a front-to-back dump.
// ----------------------------------------------------------------------------
module bounded_deque_top
	import bdq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic req_stall,
	input  wire req_beat_t req,
	output logic rsp_valid,
	input  wire logic rsp_stall,
	output rsp_beat_t rsp
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic [CNT_W-1:0] rem_q;
	logic dump_q;
	logic dump_start;
	logic rsp_valid_q;
	rsp_beat_t rsp_q;
	rsp_beat_t res;
	logic res_v;
	logic acc;
	logic load_ok;
	logic full;
	logic empty;
	cell_cmd_t cmd;
	logic signed [DATA_W-1:0] head;
	logic signed [DATA_W-1:0] back;

	assign load_ok = !rsp_valid_q || !rsp_stall;
	assign req_stall = dump_q || (rsp_valid_q && rsp_stall);
	assign acc = req_valid && !req_stall;
	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		cmd.op = OP_HOLD;
		cmd.count = count_q;
		cmd.value = req.value;
		res.data = '0;
		res.status = ST_OK;
		res.entries = ENT_W'(count_q);
		res.last = 1'b1;
		res_v = 1'b0;
		count_d = count_q;
		dump_start = 1'b0;
		if (dump_q) begin
			if (load_ok) begin
				cmd.op = OP_ROTATE;
				res.data = head;
				res.last = (rem_q == CNT_W'(1));
				res_v = 1'b1;
			end
		end else if (acc) begin
			unique case (req.mode)
				MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
					res_v = 1'b1;
					if (full) begin
						res.status = ST_FULL;
					end else begin
						cmd.op = (req.mode == MODE_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
						count_d = count_q + CNT_W'(1);
						res.entries = ENT_W'(count_d);
					end
				end
				MODE_POP_FRONT, MODE_POP_BACK: begin
					res_v = 1'b1;
					if (empty) begin
						res.status = ST_EMPTY;
					end else begin
						cmd.op = (req.mode == MODE_POP_FRONT) ? OP_POP_FRONT : OP_HOLD;
						res.data = (req.mode == MODE_POP_FRONT) ? head : back;
						count_d = count_q - CNT_W'(1);
						res.entries = ENT_W'(count_d);
					end
				end
				MODE_DUMP: begin
					if (empty) begin
						res_v = 1'b1;
						res.status = ST_EMPTY;
					end else begin
						dump_start = 1'b1;
					end
				end
				default: res_v = 1'b0;
			endcase
		end
	end

	bdq_chain u_chain (
		.clk  (clk),
		.cmd  (cmd),
		.head (head),
		.back (back)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			dump_q <= 1'b0;
			rem_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (load_ok)
				rsp_valid_q <= res_v;
			if (dump_start) begin
				dump_q <= 1'b1;
				rem_q <= count_q;
			end else if (dump_q && load_ok) begin
				rem_q <= rem_q - CNT_W'(1);
				if (rem_q == CNT_W'(1))
					dump_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok && res_v)
			rsp_q <= res;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule
`default_nettype wire
